@@ hw/rtl/dcd_pkg.sv @@
// Shared types, constants and calendar helpers for the date clamp/compare/difference unit.
// Used by dcd_day_number and date_clamp_compare_diff_unit; depends on nothing else.

package dcd_pkg;

  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DaysW  = 20;

  localparam logic [YearW-1:0] BaseYear = 12'd2000;

  // floor(x / 100) == (x * Recip100) >> RecipShift for every x below about 43000.
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int unsigned RecipShift = 19;

  // Register stages inside dcd_day_number.
  localparam int unsigned DayNumLat = 4;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] month_start(input logic [MonthW-1:0] m);
    logic [8:0] start;
    case (m)
      4'd2:  start = 9'd31;
      4'd3:  start = 9'd59;
      4'd4:  start = 9'd90;
      4'd5:  start = 9'd120;
      4'd6:  start = 9'd151;
      4'd7:  start = 9'd181;
      4'd8:  start = 9'd212;
      4'd9:  start = 9'd243;
      4'd10: start = 9'd273;
      4'd11: start = 9'd304;
      4'd12: start = 9'd334;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

@@ hw/rtl/date_clamp_compare_diff_unit.sv @@
// Top level of the date clamp/compare/difference unit: two day-number pipelines and a compare stage.
// Depends on dcd_pkg and dcd_day_number.
//
//   channel   handshake           payload
//   input     start, busy         a_year a_month a_day b_year b_month b_day
//   result    done (one cycle)    days_between a_before_b a_equals_b
//
// An item may be started in every cycle; busy stays low.
// Each item yields one result, in order, after passing through the four-stage day-number
// pipeline and then the compare/subtract stage.
// Synchronous reset clears the valid pipeline; items in flight are dropped.
// The receiver cannot stall, so no backpressure exists anywhere in the pipeline.

module date_clamp_compare_diff_unit #(
  parameter int unsigned MAX_YEAR = 4095
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dcd_pkg::YearW-1:0]     a_year,
  input  logic [dcd_pkg::MonthW-1:0]    a_month,
  input  logic [dcd_pkg::DayW-1:0]      a_day,
  input  logic [dcd_pkg::YearW-1:0]     b_year,
  input  logic [dcd_pkg::MonthW-1:0]    b_month,
  input  logic [dcd_pkg::DayW-1:0]      b_day,
  output logic                          done,
  output logic [dcd_pkg::DaysW-1:0]     days_between,
  output logic                          a_before_b,
  output logic                          a_equals_b
);

  dcd_pkg::date_t            date_a;
  dcd_pkg::date_t            date_b;
  logic [dcd_pkg::DaysW-1:0] num_a;
  logic [dcd_pkg::DaysW-1:0] num_b;
  logic [dcd_pkg::DayNumLat-1:0] valid;

  assign busy   = 1'b0;
  assign date_a = '{year: a_year, month: a_month, day: a_day};
  assign date_b = '{year: b_year, month: b_month, day: b_day};

  dcd_day_number #(.MAX_YEAR(MAX_YEAR)) u_num_a (
    .clk     (clk),
    .date    (date_a),
    .day_num (num_a)
  );

  dcd_day_number #(.MAX_YEAR(MAX_YEAR)) u_num_b (
    .clk     (clk),
    .date    (date_b),
    .day_num (num_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      valid <= {valid[dcd_pkg::DayNumLat-2:0], start};
      done  <= valid[dcd_pkg::DayNumLat-1];
    end
  end

  always_ff @(posedge clk) begin
    days_between <= (num_a > num_b) ? (num_a - num_b) : '0;
    a_before_b   <= (num_a < num_b);
    a_equals_b   <= (num_a == num_b);
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !(a_before_b && a_equals_b))
    else $error("result flags both before and equal");
  assert property (@(posedge clk) disable iff (rst) (done && a_before_b) |-> days_between == '0)
    else $error("nonzero difference when A precedes B");
  assert property (@(posedge clk) disable iff (rst) (done && a_equals_b) |-> days_between == '0)
    else $error("nonzero difference for equal dates");
  assert property (@(posedge clk) disable iff (rst)
      (done && !a_before_b && !a_equals_b) |-> days_between != '0)
    else $error("zero difference when A follows B");

endmodule

@@ hw/rtl/dcd_day_number.sv @@
// Four-stage pipeline that clamps one raw date and turns it into days since 2000-01-01.
// Depends on dcd_pkg.

module dcd_day_number #(
  parameter int unsigned MAX_YEAR = 4095
) (
  input  logic                       clk,
  input  dcd_pkg::date_t             date,
  output logic [dcd_pkg::DaysW-1:0]  day_num
);

  localparam int unsigned YearCap = (MAX_YEAR > 4095) ? 4095 : MAX_YEAR;
  localparam logic [dcd_pkg::YearW-1:0] YearTop = YearCap[dcd_pkg::YearW-1:0];

  // Stage 1: clamped year offset and month, raw day.
  logic [dcd_pkg::YearW-1:0]  s1_off;
  logic [dcd_pkg::MonthW-1:0] s1_month;
  logic [dcd_pkg::DayW-1:0]   s1_day;

  // Stage 2: quotients and the year product.
  logic [9:0]                 s2_q4;
  logic [5:0]                 s2_q100;
  logic [4:0]                 s2_q400;
  logic [4:0]                 s2_qoff;
  logic [dcd_pkg::YearW-1:0]  s2_off;
  logic [dcd_pkg::DaysW-1:0]  s2_years;
  logic [dcd_pkg::MonthW-1:0] s2_month;
  logic [dcd_pkg::DayW-1:0]   s2_day;

  // Stage 3: year, month and day parts.
  logic [dcd_pkg::DaysW-1:0]  s3_years;
  logic [8:0]                 s3_months;
  logic [dcd_pkg::DayW-1:0]   s3_days;

  logic [dcd_pkg::YearW-1:0]  year_lo;
  logic [dcd_pkg::YearW-1:0]  year_c;
  logic [dcd_pkg::MonthW-1:0] month_c;
  logic [24:0]                prod_b;
  logic [24:0]                prod_c;
  logic [24:0]                prod_o;
  logic [dcd_pkg::YearW-1:0]  off_hund;
  logic                       leap;
  logic [dcd_pkg::DayW-1:0]   lim;
  logic [dcd_pkg::DayW-1:0]   day_c;
  logic [10:0]                leaps;

  always_comb begin
    year_lo = (date.year < dcd_pkg::BaseYear) ? dcd_pkg::BaseYear : date.year;
    year_c  = (year_lo > YearTop) ? YearTop : year_lo;
    month_c = (date.month == '0 || date.month > 4'd12) ? 4'd1 : date.month;
  end

  always_ff @(posedge clk) begin
    s1_off   <= year_c - dcd_pkg::BaseYear;
    s1_month <= month_c;
    s1_day   <= date.day;
  end

  always_comb begin
    prod_b = 25'(s1_off + 12'd99) * 25'(dcd_pkg::Recip100);
    prod_c = 25'(s1_off + 12'd399) * 25'(dcd_pkg::Recip100);
    prod_o = 25'(s1_off) * 25'(dcd_pkg::Recip100);
  end

  always_ff @(posedge clk) begin
    s2_q4    <= 10'((s1_off + 12'd3) >> 2);
    s2_q100  <= 6'(prod_b >> dcd_pkg::RecipShift);
    s2_q400  <= 5'(prod_c >> (dcd_pkg::RecipShift + 2));
    s2_qoff  <= 5'(prod_o >> dcd_pkg::RecipShift);
    s2_off   <= s1_off;
    s2_years <= 20'(s1_off) * 20'd365;
    s2_month <= s1_month;
    s2_day   <= s1_day;
  end

  always_comb begin
    off_hund = 12'(s2_qoff) * 12'd100;
    leap     = (s2_off[1:0] == 2'b00) && ((s2_off != off_hund) || (s2_qoff[1:0] == 2'b00));
    lim      = (s2_month == 4'd2 && leap) ? 5'd29 : dcd_pkg::month_len(s2_month);
    day_c    = (s2_day == '0 || s2_day > lim) ? 5'd1 : s2_day;
    leaps    = 11'(s2_q4) + 11'(s2_q400) - 11'(s2_q100);
  end

  always_ff @(posedge clk) begin
    s3_years  <= s2_years + 20'(leaps);
    s3_months <= dcd_pkg::month_start(s2_month) + 9'((s2_month > 4'd2) && leap);
    s3_days   <= day_c - 5'd1;
  end

  always_ff @(posedge clk) begin
    day_num <= s3_years + 20'(s3_months) + 20'(s3_days);
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for date_clamp_compare_diff_unit: clamps date pairs, compares them
// and checks the day difference and both order flags against a predictor in this file.
// Depends on dcd_pkg and the unit's RTL only.

module tb;

  localparam int unsigned MaxYear       = 4095;
  localparam int unsigned NumRandom     = 1330;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned TailCycles    = 12;
  localparam int unsigned MaxReported   = 10;

  typedef struct {
    dcd_pkg::date_t a;
    dcd_pkg::date_t b;
    int unsigned    gap;
    bit             drain;
  } date_pair_t;

  typedef struct {
    logic [dcd_pkg::DaysW-1:0] days;
    logic                      earlier;
    logic                      same;
  } span_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [dcd_pkg::YearW-1:0]  a_year = '0;
  logic [dcd_pkg::MonthW-1:0] a_month = '0;
  logic [dcd_pkg::DayW-1:0]   a_day = '0;
  logic [dcd_pkg::YearW-1:0]  b_year = '0;
  logic [dcd_pkg::MonthW-1:0] b_month = '0;
  logic [dcd_pkg::DayW-1:0]   b_day = '0;
  logic                       done;
  logic [dcd_pkg::DaysW-1:0]  days_between;
  logic                       a_before_b;
  logic                       a_equals_b;

  date_pair_t  pending_q[$];
  span_t       span_q[$];
  date_pair_t  cur;
  bit          loaded = 1'b0;
  bit          steady = 1'b0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_drains = 0;
  int unsigned idle_cycles = 0;

  date_clamp_compare_diff_unit #(.MAX_YEAR(MaxYear)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_year(a_year), .a_month(a_month), .a_day(a_day),
    .b_year(b_year), .b_month(b_month), .b_day(b_day),
    .done(done), .days_between(days_between),
    .a_before_b(a_before_b), .a_equals_b(a_equals_b)
  );

  always #5 clk = ~clk;

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned leap_count(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    int unsigned lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && is_leap_year(y)) begin
      return 29;
    end
    return lens[m];
  endfunction

  function automatic dcd_pkg::date_t clamp_date(dcd_pkg::date_t raw);
    dcd_pkg::date_t c;
    c = raw;
    if (c.year < dcd_pkg::BaseYear) c.year = dcd_pkg::BaseYear;
    if (c.year > MaxYear) c.year = dcd_pkg::YearW'(MaxYear);
    if (c.month < 1 || c.month > 12) c.month = dcd_pkg::MonthW'(1);
    if (c.day < 1 || c.day > days_in_month(c.year, c.month)) c.day = dcd_pkg::DayW'(1);
    return c;
  endfunction

  function automatic int unsigned day_index(dcd_pkg::date_t d);
    int unsigned y;
    int unsigned n;
    y = d.year;
    n = 365 * (y - 2000) + leap_count(y - 1) - leap_count(1999);
    for (int unsigned m = 1; m < d.month; m++) begin
      n += days_in_month(y, m);
    end
    return n + d.day - 1;
  endfunction

  function automatic span_t predict_span(dcd_pkg::date_t ra, dcd_pkg::date_t rb);
    int unsigned na;
    int unsigned nb;
    span_t s;
    na = day_index(clamp_date(ra));
    nb = day_index(clamp_date(rb));
    s.days = (na > nb) ? dcd_pkg::DaysW'(na - nb) : '0;
    s.earlier = (na < nb);
    s.same = (na == nb);
    return s;
  endfunction

  function automatic dcd_pkg::date_t mk_date(int unsigned y, int unsigned m, int unsigned d);
    return dcd_pkg::date_t'({dcd_pkg::YearW'(y), dcd_pkg::MonthW'(m), dcd_pkg::DayW'(d)});
  endfunction

  function automatic dcd_pkg::date_t random_date();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    case ($urandom_range(0, 9))
      0, 1: y = $urandom_range(0, 4095);
      2: y = $urandom_range(0, 1999);
      3: y = $urandom_range(20, 40) * 100;
      default: y = $urandom_range(2000, 2120);
    endcase
    m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 28);
    if (m == 2 && $urandom_range(0, 3) == 0) d = 29;
    return mk_date(y, m, d);
  endfunction

  function automatic dcd_pkg::date_t near_date(dcd_pkg::date_t base);
    dcd_pkg::date_t d;
    d = base;
    case ($urandom_range(0, 3))
      0: d.day = dcd_pkg::DayW'($urandom_range(0, 31));
      1: d.month = dcd_pkg::MonthW'($urandom_range(0, 15));
      2: d.year = base.year + dcd_pkg::YearW'($urandom_range(0, 2)) - 12'd1;
      default: d = mk_date(base.year, base.month + 1, 1);
    endcase
    return d;
  endfunction

  task automatic queue_pair(dcd_pkg::date_t a, dcd_pkg::date_t b, bit drain);
    date_pair_t p;
    p.a = a;
    p.b = b;
    p.gap = steady ? 0 : $urandom_range(0, 15);
    p.drain = drain;
    if (drain) n_drains++;
    pending_q.push_back(p);
  endtask

  task automatic flag_error(string msg);
    n_mismatch++;
    if (n_mismatch <= MaxReported) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  // Driver: presents queued items, honoring each item's gap and full-drain request.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        span_q.push_back(predict_span(dcd_pkg::date_t'({a_year, a_month, a_day}),
                                      dcd_pkg::date_t'({b_year, b_month, b_day})));
        n_items++;
        loaded = 1'b0;
      end
      if (!loaded && pending_q.size() != 0) begin
        cur = pending_q.pop_front();
        loaded = 1'b1;
      end
      if (loaded && cur.gap != 0) begin
        cur.gap--;
        start <= 1'b0;
      end else if (loaded && !(cur.drain && span_q.size() != 0)) begin
        start <= 1'b1;
        a_year <= cur.a.year;
        a_month <= cur.a.month;
        a_day <= cur.a.day;
        b_year <= cur.b.year;
        b_month <= cur.b.month;
        b_day <= cur.b.day;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    span_t want;
    if (!rst && done) begin
      n_results++;
      if (span_q.size() == 0) begin
        flag_error($sformatf("result with no item outstanding, days %0d", days_between));
      end else begin
        want = span_q.pop_front();
        if (days_between !== want.days || a_before_b !== want.earlier ||
            a_equals_b !== want.same) begin
          flag_error($sformatf("days exp %0d got %0d, before exp %0b got %0b, equal exp %0b got %0b",
                               want.days, days_between, want.earlier, a_before_b,
                               want.same, a_equals_b));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired with %0d results outstanding.", span_q.size());
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dcd_pkg::date_t a;
    dcd_pkg::date_t b;

    queue_pair(mk_date(0, 0, 0), mk_date(0, 0, 0), 1'b0);
    queue_pair(mk_date(4095, 15, 31), mk_date(4095, 15, 31), 1'b0);
    queue_pair(mk_date(4095, 12, 31), mk_date(2000, 1, 1), 1'b0);
    queue_pair(mk_date(2000, 1, 1), mk_date(4095, 12, 31), 1'b0);
    queue_pair(mk_date(2000, 2, 29), mk_date(2000, 2, 28), 1'b0);
    queue_pair(mk_date(2100, 2, 29), mk_date(2100, 2, 1), 1'b0);
    queue_pair(mk_date(2400, 3, 1), mk_date(2400, 2, 29), 1'b0);
    queue_pair(mk_date(2004, 3, 1), mk_date(2004, 2, 28), 1'b0);
    queue_pair(mk_date(2001, 4, 31), mk_date(2001, 4, 1), 1'b0);
    queue_pair(mk_date(2010, 13, 15), mk_date(2010, 1, 15), 1'b1);
    queue_pair(mk_date(2010, 0, 31), mk_date(2010, 1, 30), 1'b0);
    queue_pair(mk_date(2010, 5, 0), mk_date(2010, 5, 1), 1'b0);
    queue_pair(mk_date(1999, 6, 15), mk_date(2000, 6, 15), 1'b0);
    queue_pair(mk_date(0, 1, 1), mk_date(2000, 1, 2), 1'b0);
    queue_pair(mk_date(2001, 1, 1), mk_date(2000, 12, 31), 1'b0);
    queue_pair(mk_date(2005, 2, 29), mk_date(2005, 1, 31), 1'b0);
    queue_pair(mk_date(2005, 1, 1), mk_date(2004, 3, 1), 1'b0);
    queue_pair(mk_date(2000, 3, 1), mk_date(2000, 1, 1), 1'b0);
    queue_pair(mk_date(3000, 12, 31), mk_date(2999, 12, 31), 1'b0);
    queue_pair(mk_date(2730, 10, 21), mk_date(1365, 5, 10), 1'b0);

    for (int unsigned i = 0; i < NumRandom; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      a = random_date();
      case ($urandom_range(0, 9))
        0, 1, 2: b = a;
        3, 4, 5: b = near_date(a);
        default: b = random_date();
      endcase
      if ($urandom_range(0, 1) == 1) begin
        queue_pair(a, b, (i % 200 == 199) || ($urandom_range(0, 99) == 0));
      end else begin
        queue_pair(b, a, (i % 200 == 199) || ($urandom_range(0, 99) == 0));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || loaded || span_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d date pairs and checked %0d results, including %0d full drains.",
             n_items, n_results, n_drains);
    $display("Mismatches: %0d.", n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dcd_pkg.sv
hw/rtl/dcd_day_number.sv
hw/rtl/date_clamp_compare_diff_unit.sv
dv/tb.sv
